// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the receiver RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// An implication within the same clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swtr_pkg.sv -----
// Types, constants and the header checksum function of the stop-and-wait receiver.
// Depends on nothing; used by stop_wait_transfer_receiver.
package swtr_pkg;

    // Flag byte codes of the packet header.
    localparam logic [7:0] FLAG_DATA   = 8'h00;
    localparam logic [7:0] FLAG_SYN    = 8'h01;
    localparam logic [7:0] FLAG_ACK    = 8'h02;
    localparam logic [7:0] FLAG_SYNACK = 8'h03;
    localparam logic [7:0] FLAG_FIN    = 8'h04;
    localparam logic [7:0] FLAG_END    = 8'h07;

    // Largest payload counted for one data packet.
    localparam logic [15:0] MAX_PAYLOAD = 16'd4096;

    // Reset value of the timeout register.
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    typedef enum logic [2:0] {
        PH_WAIT_SYN    = 3'd0,
        PH_WAIT_SYNACK = 3'd1,
        PH_NAME        = 3'd2,
        PH_FILE        = 3'd3,
        PH_WAIT_FIN    = 3'd4,
        PH_CLOSED      = 3'd5,
        PH_FAILED      = 3'd6
    } phase_t;

    // One outgoing result.
    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] stream_length;
        logic        stream_id;
        logic        payload_accept;
        logic [7:0]  seq;
        logic [7:0]  flag;
        logic [15:0] datasize;
        logic [15:0] sum;
    } result_t;

    // Ones'-complement sum of three words with end-around carry, inverted.
    function automatic logic [15:0] csum3(input logic [15:0] w0,
                                          input logic [15:0] w1,
                                          input logic [15:0] w2);
        logic [16:0] s1;
        logic [15:0] a1;
        logic [16:0] s2;
        logic [15:0] a2;
        s1 = {1'b0, w0} + {1'b0, w1};
        a1 = s1[16] ? (s1[15:0] + 16'd1) : s1[15:0];
        s2 = {1'b0, a1} + {1'b0, w2};
        a2 = s2[16] ? (s2[15:0] + 16'd1) : s2[15:0];
        return ~a2;
    endfunction

endpackage

// ----- rtl/stop_wait_transfer_receiver.sv -----
// Top level of the stop-and-wait file transfer receiver (header and timer level).
// Depends on swtr_pkg and on assert_macros.svh for its assertions.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  received header or timer tick
//  m_axis    out        m_axis_tvalid/m_axis_tready  header to send plus status
//  cfg       in         cfg_valid/cfg_ready          timeout_ticks write data
//
// One transaction is accepted per cycle while the result register can move on.
// An accepted transaction waits in the input register until the result register is free or
// being emptied; its result, if any, is then loaded into the output register.
// The active-low asynchronous reset returns the link to waiting for SYN and sets
// the timeout to 200 ticks; no clearing pass is needed.
// A stall on m_axis holds the input register, which then drops s_axis_tready.
`include "assert_macros.svh"

module stop_wait_transfer_receiver (
    input  logic         clk,
    input  logic         rst_n,
    // Incoming transactions.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: in_sum[15:0], in_datasize[15:0], in_flag[7:0], in_seq[7:0]
    input  logic [47:0]  s_axis_tdata,
    // tuser: req_type (0 header, 1 timer tick)
    input  logic [0:0]   s_axis_tuser,
    // Outgoing transactions.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: out_sum[15:0], out_datasize[15:0], out_flag[7:0], out_seq[7:0],
    // stream_length[31:0], phase[2:0], zero fill[4:0]
    output logic [87:0]  m_axis_tdata,
    // tuser from bit 0: payload_accept, stream_id
    output logic [1:0]   m_axis_tuser,
    // Configuration write channel for timeout_ticks.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    // Input register: one accepted transaction waiting to be processed.
    logic        in_valid_reg, in_valid_next;
    logic        in_tick_reg, in_tick_next;
    logic [15:0] in_sum_reg, in_sum_next;
    logic [15:0] in_size_reg, in_size_next;
    logic [7:0]  in_flag_reg, in_flag_next;
    logic [7:0]  in_seq_reg, in_seq_next;

    // Link state.
    swtr_pkg::phase_t link_phase_reg, link_phase_next;
    logic [7:0]  expected_seq_reg, expected_seq_next;
    logic [31:0] byte_total_reg, byte_total_next;
    logic [15:0] wait_timer_reg, wait_timer_next;
    logic [7:0]  held_seq_reg, held_seq_next;
    logic [15:0] held_size_reg, held_size_next;
    logic [15:0] timeout_ticks_reg, timeout_ticks_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    swtr_pkg::result_t out_res_reg, out_res_next;

    logic              out_free;
    logic              proc;
    logic              accept;
    logic              hdr_ok;
    logic              res_valid;
    swtr_pkg::result_t res;
    logic [15:0]       res_size;
    logic [7:0]        res_flag;
    logic [7:0]        res_seq;
    logic [15:0]       add_bytes;
    logic [32:0]       total_sum;
    logic [31:0]       total_sat;

    // The processing stage may only move when the result register is free or being
    // emptied this cycle; the input register refills in the same cycle it drains.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || proc;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.phase, out_res_reg.stream_length,
                            out_res_reg.seq, out_res_reg.flag,
                            out_res_reg.datasize, out_res_reg.sum};
    assign m_axis_tuser  = {out_res_reg.stream_id, out_res_reg.payload_accept};

    // A received header is valid when its ones'-complement sum comes out as zero.
    assign hdr_ok = (swtr_pkg::csum3(in_sum_reg, in_size_reg, {in_seq_reg, in_flag_reg})
                     == 16'd0);

    // Byte count of an in-order data packet, clamped, and the saturating running total.
    assign add_bytes = (in_size_reg > swtr_pkg::MAX_PAYLOAD) ? swtr_pkg::MAX_PAYLOAD
                                                             : in_size_reg;
    assign total_sum = {1'b0, byte_total_reg} + {17'd0, add_bytes};
    assign total_sat = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];

    always_comb
    begin
        in_valid_next     = in_valid_reg;
        in_tick_next      = in_tick_reg;
        in_sum_next       = in_sum_reg;
        in_size_next      = in_size_reg;
        in_flag_next      = in_flag_reg;
        in_seq_next       = in_seq_reg;
        link_phase_next   = link_phase_reg;
        expected_seq_next = expected_seq_reg;
        byte_total_next   = byte_total_reg;
        wait_timer_next   = wait_timer_reg;
        held_seq_next     = held_seq_reg;
        held_size_next    = held_size_reg;
        timeout_ticks_next = cfg_valid ? cfg_data : timeout_ticks_reg;

        res_valid              = 1'b0;
        res_size               = 16'd0;
        res_flag               = swtr_pkg::FLAG_ACK;
        res_seq                = 8'd0;
        res.payload_accept     = 1'b0;
        res.stream_id          = 1'b0;
        res.stream_length      = byte_total_reg;
        res.phase              = swtr_pkg::PH_WAIT_SYN;

        if (proc)
        begin
            if (in_tick_reg)
            begin
                // Timer ticks only matter while the SYN-ACK is awaited.
                if (link_phase_reg == swtr_pkg::PH_WAIT_SYNACK)
                begin
                    if (wait_timer_reg >= timeout_ticks_reg)
                    begin
                        wait_timer_next = 16'd0;
                        res_valid       = 1'b1;
                        res_size        = held_size_reg;
                        res_seq         = held_seq_reg;
                    end
                    else
                    begin
                        wait_timer_next = wait_timer_reg + 16'd1;
                    end
                end
            end
            else
            begin
                case (link_phase_reg)
                    swtr_pkg::PH_WAIT_SYN:
                    begin
                        if (in_flag_reg == swtr_pkg::FLAG_SYN && hdr_ok)
                        begin
                            held_seq_next   = in_seq_reg;
                            held_size_next  = in_size_reg;
                            wait_timer_next = 16'd0;
                            link_phase_next = swtr_pkg::PH_WAIT_SYNACK;
                            res_valid       = 1'b1;
                            res_size        = in_size_reg;
                            res_seq         = in_seq_reg;
                        end
                    end
                    swtr_pkg::PH_WAIT_SYNACK:
                    begin
                        // Anything other than a good SYN-ACK ends the connection attempt.
                        link_phase_next = (in_flag_reg == swtr_pkg::FLAG_SYNACK && hdr_ok)
                                          ? swtr_pkg::PH_NAME : swtr_pkg::PH_FAILED;
                    end
                    swtr_pkg::PH_NAME, swtr_pkg::PH_FILE:
                    begin
                        res.stream_id = (link_phase_reg == swtr_pkg::PH_FILE);
                        if (in_flag_reg == swtr_pkg::FLAG_DATA)
                        begin
                            res_valid = 1'b1;
                            if (in_seq_reg == expected_seq_reg)
                            begin
                                byte_total_next    = total_sat;
                                expected_seq_next  = expected_seq_reg + 8'd1;
                                res_seq            = expected_seq_reg;
                                res.payload_accept = 1'b1;
                                res.stream_length  = total_sat;
                            end
                            else
                            begin
                                // Re-acknowledge the last packet taken in order.
                                res_seq = expected_seq_reg - 8'd1;
                            end
                        end
                        else if (in_flag_reg == swtr_pkg::FLAG_END && hdr_ok)
                        begin
                            link_phase_next   = (link_phase_reg == swtr_pkg::PH_NAME)
                                                ? swtr_pkg::PH_FILE : swtr_pkg::PH_WAIT_FIN;
                            expected_seq_next = 8'd0;
                            byte_total_next   = 32'd0;
                            res_valid         = 1'b1;
                            res_size          = in_size_reg;
                            res_flag          = swtr_pkg::FLAG_END;
                            res_seq           = in_seq_reg;
                        end
                    end
                    swtr_pkg::PH_WAIT_FIN:
                    begin
                        if (in_flag_reg == swtr_pkg::FLAG_FIN && hdr_ok)
                        begin
                            link_phase_next = swtr_pkg::PH_CLOSED;
                            res_valid       = 1'b1;
                            res_size        = in_size_reg;
                            res_seq         = in_seq_reg;
                        end
                    end
                    default:
                    begin
                        // Closed or failed: every input is dropped.
                    end
                endcase
            end
        end

        res.datasize = res_size;
        res.flag     = res_flag;
        res.seq      = res_seq;
        res.sum      = swtr_pkg::csum3(16'd0, res_size, {res_seq, res_flag});
        res.phase    = link_phase_next;

        // Input register: drains when processed, refills on acceptance.
        if (proc)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_tick_next  = s_axis_tuser[0];
            in_sum_next   = s_axis_tdata[15:0];
            in_size_next  = s_axis_tdata[31:16];
            in_flag_next  = s_axis_tdata[39:32];
            in_seq_next   = s_axis_tdata[47:40];
        end

        // Result register.
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            link_phase_reg    <= swtr_pkg::PH_WAIT_SYN;
            expected_seq_reg  <= 8'd0;
            byte_total_reg    <= 32'd0;
            wait_timer_reg    <= 16'd0;
            held_seq_reg      <= 8'd0;
            held_size_reg     <= 16'd0;
            timeout_ticks_reg <= swtr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            link_phase_reg    <= link_phase_next;
            expected_seq_reg  <= expected_seq_next;
            byte_total_reg    <= byte_total_next;
            wait_timer_reg    <= wait_timer_next;
            held_seq_reg      <= held_seq_next;
            held_size_reg     <= held_size_next;
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        in_tick_reg <= in_tick_next;
        in_sum_reg  <= in_sum_next;
        in_size_reg <= in_size_next;
        in_flag_reg <= in_flag_next;
        in_seq_reg  <= in_seq_next;
        out_res_reg <= out_res_next;
    end

    // A result is only ever produced once a SYN has been answered and before failure.
    `ASSERT_IMPLIES(a_result_phase, clk, rst_n, m_axis_tvalid,
        (out_res_reg.phase >= swtr_pkg::PH_WAIT_SYNACK) &&
        (out_res_reg.phase <= swtr_pkg::PH_CLOSED), "result carries a phase that cannot emit")
    // A payload that is taken in order is always answered by a plain ACK with no size.
    `ASSERT_IMPLIES(a_accept_ack, clk, rst_n, m_axis_tvalid && out_res_reg.payload_accept,
        (out_res_reg.flag == swtr_pkg::FLAG_ACK) && (out_res_reg.datasize == 16'd0),
        "accepted payload not acknowledged as a data ACK")
    // Back-pressure upstream only arises from a held item behind a full result register.
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !s_axis_tready,
        in_valid_reg && out_valid_reg && !m_axis_tready, "input stalled without cause")

endmodule
